// ===== hdl/btps_pkg.sv =====
`timescale 1ns / 1ps

package btps_pkg;

  localparam int FAIL_LIMIT = 5;
  localparam int EMPTY_MV   = 3200;
  localparam int FULL_MV    = 4200;

  localparam logic [2:0] FUNC_START      = 3'd0;
  localparam logic [2:0] FUNC_TICK       = 3'd1;
  localparam logic [2:0] FUNC_ACTIVITY   = 3'd2;
  localparam logic [2:0] FUNC_CONNECT    = 3'd3;
  localparam logic [2:0] FUNC_DISCONNECT = 3'd4;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_LOW_BATT = 3'd1;
  localparam logic [2:0] EV_THERMAL  = 3'd2;
  localparam logic [2:0] EV_IDLE     = 3'd3;
  localparam logic [2:0] EV_SLEEP    = 3'd4;

  localparam logic [1:0] REPLY_ACCEPTED = 2'd0;
  localparam logic [1:0] REPLY_REJECTED = 2'd1;

  localparam logic [2:0] REG_THERMAL_INTERVAL = 3'd0;
  localparam logic [2:0] REG_BATTERY_INTERVAL = 3'd1;
  localparam logic [2:0] REG_IDLE_TIMEOUT     = 3'd2;
  localparam logic [2:0] REG_SLEEP_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_LOW_CUTOFF       = 3'd4;
  localparam logic [2:0] REG_OVERVOLTAGE      = 3'd5;
  localparam logic [2:0] REG_TEMP_LIMITS      = 3'd6;
  localparam logic [2:0] REG_FEATURES         = 3'd7;

  localparam int CFG_W = 40;

  localparam logic [31:0] THERMAL_INTERVAL_RST = 32'd5000;
  localparam logic [31:0] BATTERY_INTERVAL_RST = 32'd60000;
  localparam logic [31:0] IDLE_TIMEOUT_RST     = 32'd3000;
  localparam logic [31:0] SLEEP_TIMEOUT_RST    = 32'd300000;
  localparam logic [12:0] LOW_CUTOFF_RST       = 13'd3200;
  localparam logic [12:0] OVERVOLTAGE_RST      = 13'd4250;
  localparam logic [39:0] TEMP_LIMITS_RST      = 40'h3C_2D28_0500;
  localparam logic [2:0]  FEATURES_RST         = 3'd7;

  localparam logic signed [7:0] TEMP_UNKNOWN = -8'sd128;

  // The percentage is worked out as a multiplication by a scaled reciprocal of the span.
  localparam int PCT_DIV   = (FULL_MV > EMPTY_MV) ? (FULL_MV - EMPTY_MV) : 1;
  localparam int PCT_SHIFT = 13 + $clog2(PCT_DIV + 1);
  localparam longint PCT_MUL = ((64'd100 << PCT_SHIFT) + longint'(PCT_DIV) - 64'd1)
                               / longint'(PCT_DIV);
  localparam int PCT_MUL_W = $clog2(PCT_MUL + 1);
  localparam logic [PCT_MUL_W-1:0] PCT_MUL_V = PCT_MUL[PCT_MUL_W-1:0];

  typedef struct packed {
    logic [2:0]        func;
    logic [31:0]       now_ms;
    logic              usb_power_in;
    logic              vbat_ok;
    logic [12:0]       vbat_sample_mv;
    logic              ntc_ok;
    logic signed [7:0] temp_sample_c;
    logic [1:0]        link_reply;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_code;
    logic              charge_on;
    logic              sensor_power_on;
    logic [6:0]        battery_percent;
    logic [12:0]       cached_vbat_mv;
    logic signed [7:0] cached_temp_c;
    logic              usb_power_now;
    logic              ask_active_params;
    logic              ask_idle_params;
  } out_item_t;

  function automatic logic [6:0] pct_of(input logic [12:0] mv);
    logic [12:0]              x;
    logic [13+PCT_MUL_W-1:0]  p;
    logic [6:0]               r;
    x = mv - 13'(EMPTY_MV);
    p = (13+PCT_MUL_W)'(x) * (13+PCT_MUL_W)'(PCT_MUL_V);
    if (mv <= 13'(EMPTY_MV)) begin
      r = 7'd0;
    end else if (mv >= 13'(FULL_MV)) begin
      r = 7'd100;
    end else begin
      r = 7'(p >> PCT_SHIFT);
    end
    return r;
  endfunction

endpackage

// ===== hdl/battery_thermal_power_supervisor.sv =====
`timescale 1ns / 1ps

// Battery, thermal and power supervisor.
// Events (start, tick, activity, connect, disconnect) arrive on the in_ channel with a
// millisecond timestamp and the latest sensor readings; each event gives exactly one
// status beat on the out_ channel, in order. A beat is taken at a clock edge where its
// valid is high and its stall is low.
// An accepted event is held in an input register; from there the whole step is
// evaluated and the status is written to the output register once that register is
// free or its beat is taken. One event is taken every cycle as long as the receiver
// keeps up; the rate is set by the single evaluation stage, which updates the state
// while writing the result.
// When the receiver stalls, the output register holds its beat, the next event waits
// in the input register and in_stall is raised once both are full.
// The cfg_ port writes one register per cycle with cfg_wr_en; the user is to use it
// only while no event is in flight, as the block itself does not enforce this.
// Synchronous reset clears both stages, returns all timers, flags and caches to zero
// (temperature to unknown) and loads the register defaults.
module battery_thermal_power_supervisor
  import btps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  typedef struct packed {
    logic charging;
    logic heat;
  } chg_t;

  logic [31:0] thermal_interval_r, battery_interval_r, idle_timeout_r, sleep_timeout_r;
  logic [12:0] low_cutoff_r, overvoltage_r;
  logic [39:0] temp_limits_r;
  logic [2:0]  features_r;

  logic      in_valid_r, out_valid_r, advance;
  in_item_t  in_item_r;
  out_item_t out_item_r, out_item_nxt;

  logic [31:0] act_stamp_r, act_stamp_nxt, bat_stamp_r, bat_stamp_nxt;
  logic [31:0] thm_stamp_r, thm_stamp_nxt;
  logic        link_up_r, link_up_nxt, interacting_r, interacting_nxt;
  logic        fast_req_r, fast_req_nxt, fast_ref_r, fast_ref_nxt;
  logic [2:0]  fails_r, fails_nxt;
  logic [12:0] vbat_r, vbat_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic        rail_r, rail_nxt, lowlock_r, lowlock_nxt;
  logic signed [7:0] temp_r, temp_nxt;
  logic        charging_r, charging_nxt, usb_r, usb_nxt, heat_r, heat_nxt;

  function automatic chg_t judge(input chg_t cur, input logic usb,
                                 input logic signed [7:0] t, input logic [12:0] vb,
                                 input logic [39:0] lim, input logic [12:0] ovr,
                                 input logic en);
    chg_t r;
    logic over;
    r = cur;
    over = (vb != 13'd0) && (vb >= ovr);
    if (en) begin
      if (!usb) begin
        r.charging = 1'b0;
        r.heat = 1'b0;
      end else begin
        if (t != TEMP_UNKNOWN) begin
          if (t >= $signed(lim[31:24]) || t <= $signed(lim[7:0])) begin
            r.heat = 1'b1;
          end else if (cur.heat && t <= $signed(lim[23:16]) && t >= $signed(lim[15:8])) begin
            r.heat = 1'b0;
          end
        end
        r.charging = !r.heat && !over;
      end
    end
    return r;
  endfunction

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    logic        done;
    logic [2:0]  ev;
    logic        ask_act, ask_idle;
    logic [31:0] period;
    logic [6:0]  pct_in;
    chg_t        jc;
    done = 1'b0;
    ev = EV_NONE;
    ask_act = 1'b0;
    ask_idle = 1'b0;
    period = usb_r ? thermal_interval_r : battery_interval_r;
    pct_in = pct_of(in_item_r.vbat_sample_mv);
    jc = '0;
    act_stamp_nxt = act_stamp_r;
    bat_stamp_nxt = bat_stamp_r;
    thm_stamp_nxt = thm_stamp_r;
    link_up_nxt = link_up_r;
    interacting_nxt = interacting_r;
    fast_req_nxt = fast_req_r;
    fast_ref_nxt = fast_ref_r;
    fails_nxt = fails_r;
    vbat_nxt = vbat_r;
    pct_nxt = pct_r;
    rail_nxt = rail_r;
    lowlock_nxt = lowlock_r;
    temp_nxt = temp_r;
    charging_nxt = charging_r;
    usb_nxt = usb_r;
    heat_nxt = heat_r;
    case (in_item_r.func)
      FUNC_START: begin
        act_stamp_nxt = in_item_r.now_ms;
        bat_stamp_nxt = in_item_r.now_ms;
        thm_stamp_nxt = in_item_r.now_ms;
        link_up_nxt = 1'b0;
        interacting_nxt = 1'b0;
        fast_req_nxt = 1'b0;
        fast_ref_nxt = 1'b0;
        fails_nxt = 3'd0;
        vbat_nxt = 13'd0;
        pct_nxt = 7'd0;
        lowlock_nxt = 1'b0;
        temp_nxt = TEMP_UNKNOWN;
        usb_nxt = features_r[2] && in_item_r.usb_power_in;
        rail_nxt = 1'b1;
        if (in_item_r.vbat_ok) begin
          vbat_nxt = in_item_r.vbat_sample_mv;
          pct_nxt = pct_in;
          lowlock_nxt = (in_item_r.vbat_sample_mv < low_cutoff_r) && !usb_nxt;
        end
        if (features_r[0] && in_item_r.ntc_ok) begin
          temp_nxt = in_item_r.temp_sample_c;
        end
        jc = judge(2'b00, usb_nxt, temp_nxt, vbat_nxt, temp_limits_r, overvoltage_r,
                   features_r[1]);
        charging_nxt = jc.charging;
        heat_nxt = jc.heat;
      end
      FUNC_TICK: begin
        if (features_r[2]) begin
          usb_nxt = in_item_r.usb_power_in;
        end
        period = usb_nxt ? thermal_interval_r : battery_interval_r;
        if (lowlock_r) begin
          if (!usb_nxt) begin
            ev = EV_LOW_BATT;
            done = 1'b1;
          end else begin
            lowlock_nxt = 1'b0;
            act_stamp_nxt = in_item_r.now_ms;
          end
        end
        if (!done && features_r[0] && (in_item_r.now_ms - thm_stamp_r) >= period) begin
          thm_stamp_nxt = in_item_r.now_ms;
          if (in_item_r.ntc_ok) begin
            temp_nxt = in_item_r.temp_sample_c;
            if (temp_nxt != TEMP_UNKNOWN && temp_nxt >= $signed(temp_limits_r[39:32])) begin
              if (features_r[1]) begin
                charging_nxt = 1'b0;
              end
              ev = EV_THERMAL;
              done = 1'b1;
            end
          end
          if (!done) begin
            jc = judge({charging_nxt, heat_nxt}, usb_nxt, temp_nxt, vbat_nxt,
                       temp_limits_r, overvoltage_r, features_r[1]);
            charging_nxt = jc.charging;
            heat_nxt = jc.heat;
          end
        end
        if (!done && link_up_r && interacting_r &&
            (in_item_r.now_ms - act_stamp_nxt) >= idle_timeout_r) begin
          ask_idle = fast_req_r;
          interacting_nxt = 1'b0;
          fast_req_nxt = 1'b0;
          ev = EV_IDLE;
          done = 1'b1;
        end
        if (!done && (in_item_r.now_ms - bat_stamp_r) >= battery_interval_r) begin
          bat_stamp_nxt = in_item_r.now_ms;
          if (in_item_r.vbat_ok) begin
            fails_nxt = 3'd0;
            vbat_nxt = in_item_r.vbat_sample_mv;
            pct_nxt = pct_in;
            if (usb_nxt && features_r[1] && in_item_r.vbat_sample_mv >= overvoltage_r) begin
              charging_nxt = 1'b0;
            end
            if (in_item_r.vbat_sample_mv < low_cutoff_r) begin
              lowlock_nxt = !usb_nxt;
              ev = EV_LOW_BATT;
              done = 1'b1;
            end
          end else begin
            if (fails_r != 3'd7) begin
              fails_nxt = fails_r + 3'd1;
            end
            if (fails_nxt >= 3'(FAIL_LIMIT)) begin
              lowlock_nxt = !usb_nxt;
              ev = EV_LOW_BATT;
              done = 1'b1;
            end
          end
          if (!done) begin
            jc = judge({charging_nxt, heat_nxt}, usb_nxt, temp_nxt, vbat_nxt,
                       temp_limits_r, overvoltage_r, features_r[1]);
            charging_nxt = jc.charging;
            heat_nxt = jc.heat;
          end
        end
        if (!done && link_up_r && !interacting_r &&
            (in_item_r.now_ms - act_stamp_nxt) >= sleep_timeout_r) begin
          if (usb_nxt) begin
            act_stamp_nxt = in_item_r.now_ms;
          end else begin
            rail_nxt = 1'b0;
            ev = EV_SLEEP;
          end
        end
      end
      FUNC_ACTIVITY: begin
        act_stamp_nxt = in_item_r.now_ms;
        rail_nxt = 1'b1;
        if (link_up_r) begin
          interacting_nxt = 1'b1;
          if (!fast_req_r && !fast_ref_r) begin
            ask_act = 1'b1;
            if (in_item_r.link_reply == REPLY_ACCEPTED) begin
              fast_req_nxt = 1'b1;
            end else if (in_item_r.link_reply == REPLY_REJECTED) begin
              fast_ref_nxt = 1'b1;
            end
          end
        end
      end
      FUNC_CONNECT: begin
        link_up_nxt = 1'b1;
        interacting_nxt = 1'b0;
        act_stamp_nxt = in_item_r.now_ms;
        fast_req_nxt = 1'b0;
        fast_ref_nxt = 1'b0;
      end
      FUNC_DISCONNECT: begin
        link_up_nxt = 1'b0;
        interacting_nxt = 1'b0;
        fast_req_nxt = 1'b0;
        fast_ref_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    out_item_nxt.event_code = ev;
    out_item_nxt.charge_on = charging_nxt;
    out_item_nxt.sensor_power_on = rail_nxt;
    out_item_nxt.battery_percent = pct_nxt;
    out_item_nxt.cached_vbat_mv = vbat_nxt;
    out_item_nxt.cached_temp_c = temp_nxt;
    out_item_nxt.usb_power_now = usb_nxt;
    out_item_nxt.ask_active_params = ask_act;
    out_item_nxt.ask_idle_params = ask_idle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thermal_interval_r <= THERMAL_INTERVAL_RST;
      battery_interval_r <= BATTERY_INTERVAL_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      sleep_timeout_r <= SLEEP_TIMEOUT_RST;
      low_cutoff_r <= LOW_CUTOFF_RST;
      overvoltage_r <= OVERVOLTAGE_RST;
      temp_limits_r <= TEMP_LIMITS_RST;
      features_r <= FEATURES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THERMAL_INTERVAL: thermal_interval_r <= cfg_wdata[31:0];
        REG_BATTERY_INTERVAL: battery_interval_r <= cfg_wdata[31:0];
        REG_IDLE_TIMEOUT:     idle_timeout_r <= cfg_wdata[31:0];
        REG_SLEEP_TIMEOUT:    sleep_timeout_r <= cfg_wdata[31:0];
        REG_LOW_CUTOFF:       low_cutoff_r <= cfg_wdata[12:0];
        REG_OVERVOLTAGE:      overvoltage_r <= cfg_wdata[12:0];
        REG_TEMP_LIMITS:      temp_limits_r <= cfg_wdata[39:0];
        REG_FEATURES:         features_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_valid_r || advance) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_valid_r || advance) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_stamp_r <= '0;
      bat_stamp_r <= '0;
      thm_stamp_r <= '0;
      link_up_r <= 1'b0;
      interacting_r <= 1'b0;
      fast_req_r <= 1'b0;
      fast_ref_r <= 1'b0;
      fails_r <= '0;
      vbat_r <= '0;
      pct_r <= '0;
      rail_r <= 1'b0;
      lowlock_r <= 1'b0;
      temp_r <= TEMP_UNKNOWN;
      charging_r <= 1'b0;
      usb_r <= 1'b0;
      heat_r <= 1'b0;
    end else if (advance) begin
      act_stamp_r <= act_stamp_nxt;
      bat_stamp_r <= bat_stamp_nxt;
      thm_stamp_r <= thm_stamp_nxt;
      link_up_r <= link_up_nxt;
      interacting_r <= interacting_nxt;
      fast_req_r <= fast_req_nxt;
      fast_ref_r <= fast_ref_nxt;
      fails_r <= fails_nxt;
      vbat_r <= vbat_nxt;
      pct_r <= pct_nxt;
      rail_r <= rail_nxt;
      lowlock_r <= lowlock_nxt;
      temp_r <= temp_nxt;
      charging_r <= charging_nxt;
      usb_r <= usb_nxt;
      heat_r <= heat_nxt;
    end
  end

endmodule
